// ----- rtl/div256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// div256_pkg
// Shared widths, defaults and the per-stage control struct of the divider.
// ----------------------------------------------------------------------------
package div256_pkg;

  localparam int WORD_WIDTH            = 64;
  localparam int DIVIDEND_WIDTH        = 256;
  localparam int DIVISOR_MAX_WIDTH     = 128;
  localparam int DIVISOR_WIDTH_DEFAULT = 128;

  // control that rides along with each item through the stages
  typedef struct packed {
    logic valid;
    logic neg_q;
    logic neg_r;
    logic dz;
  } div256_ctl_t;

endpackage

// ----- rtl/div256_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// div256 channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface div256_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic [div256_pkg::WORD_WIDTH-1:0]   dividend_w0;
  logic [div256_pkg::WORD_WIDTH-1:0]   dividend_w1;
  logic [div256_pkg::WORD_WIDTH-1:0]   dividend_w2;
  logic [div256_pkg::WORD_WIDTH-1:0]   dividend_w3;
  logic [div256_pkg::WORD_WIDTH-1:0]   divisor_lo;
  logic [div256_pkg::WORD_WIDTH-1:0]   divisor_hi;

  modport source (
    output valid, req_type, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
           divisor_lo, divisor_hi,
    input  ready
  );
  modport sink (
    input  valid, req_type, dividend_w0, dividend_w1, dividend_w2, dividend_w3,
           divisor_lo, divisor_hi,
    output ready
  );
endinterface

interface div256_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [div256_pkg::WORD_WIDTH-1:0]   quotient_w0;
  logic [div256_pkg::WORD_WIDTH-1:0]   quotient_w1;
  logic [div256_pkg::WORD_WIDTH-1:0]   quotient_w2;
  logic [div256_pkg::WORD_WIDTH-1:0]   quotient_w3;
  logic [div256_pkg::WORD_WIDTH-1:0]   remainder_lo;
  logic [div256_pkg::WORD_WIDTH-1:0]   remainder_hi;
  logic                                div_by_zero;

  modport source (
    output valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
           remainder_lo, remainder_hi, div_by_zero,
    input  ready
  );
  modport sink (
    input  valid, quotient_w0, quotient_w1, quotient_w2, quotient_w3,
           remainder_lo, remainder_hi, div_by_zero,
    output ready
  );
endinterface

// ----- rtl/divide_256_by_128_signed_unsigned_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divide_256_by_128_signed_unsigned_core
// Pipelined signed/unsigned 256-bit by DIVISOR_WIDTH-bit integer divider.
// ----------------------------------------------------------------------------
// usage
//   req channel carries req_type (0 unsigned, 1 signed), the dividend as four
//   64-bit words and the divisor as two 64-bit words; only the low
//   DIVISOR_WIDTH divisor bits count, the top one is the sign when signed.
//   rsp channel returns the 256-bit quotient, the 128-bit remainder and
//   div_by_zero; a zero divisor gives zero quotient and remainder.
//   signed division truncates toward zero, the remainder follows the
//   dividend sign, and the most negative dividend over minus one wraps.
// timing
//   one stage takes magnitudes, 256 stages each retire one quotient bit
//   with a DIVISOR_WIDTH+1 bit trial subtract, and one stage restores
//   signs into the output register.
//   throughput is one transfer per cycle while the receiver keeps up.
// reset and stall
//   rst clears every valid bit; payload registers are left as they are.
//   while a result sits in the output register and rsp.ready is low, the
//   whole pipeline holds and req.ready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module divide_256_by_128_signed_unsigned_core #(
  parameter int DIVISOR_WIDTH = div256_pkg::DIVISOR_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  div256_req_if.sink   req,
  div256_rsp_if.source rsp
);

  localparam int NW    = div256_pkg::DIVIDEND_WIDTH;
  localparam int WW    = div256_pkg::WORD_WIDTH;
  localparam int RW    = div256_pkg::DIVISOR_MAX_WIDTH;
  localparam int STEPS = NW;

  logic en;

  // front stage: magnitudes and signs
  logic [NW-1:0]            n_raw;
  logic [RW-1:0]            d_full;
  logic [DIVISOR_WIDTH-1:0] d_raw;
  logic                     neg_n;
  logic                     neg_d;
  logic [NW-1:0]            n_mag;
  logic [DIVISOR_WIDTH-1:0] d_mag;
  div256_pkg::div256_ctl_t  ctl_next;

  div256_pkg::div256_ctl_t  st_ctl [0:STEPS];
  logic [NW-1:0]            st_nq  [0:STEPS];
  logic [DIVISOR_WIDTH-1:0] st_r   [0:STEPS];
  logic [DIVISOR_WIDTH-1:0] st_d   [0:STEPS];

  div256_pkg::div256_ctl_t  pre_ctl;
  logic [NW-1:0]            pre_nq;
  logic [DIVISOR_WIDTH-1:0] pre_d;

  // back stage: sign restore
  div256_pkg::div256_ctl_t  last_ctl;
  logic [NW-1:0]            last_q;
  logic [DIVISOR_WIDTH-1:0] last_r;
  logic [RW-1:0]            r_ext;
  logic [NW-1:0]            q_next;
  logic [RW-1:0]            r_next;

  // global advance: the output register is empty or being drained
  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  always_comb begin
    n_raw  = {req.dividend_w3, req.dividend_w2, req.dividend_w1, req.dividend_w0};
    d_full = {req.divisor_hi, req.divisor_lo};
    d_raw  = d_full[DIVISOR_WIDTH-1:0];
    neg_n  = req.req_type & n_raw[NW-1];
    neg_d  = req.req_type & d_raw[DIVISOR_WIDTH-1];
    n_mag  = neg_n ? (~n_raw + NW'(1)) : n_raw;
    d_mag  = neg_d ? (~d_raw + DIVISOR_WIDTH'(1)) : d_raw;
    ctl_next.valid = req.valid;
    ctl_next.neg_q = neg_n ^ neg_d;
    ctl_next.neg_r = neg_n;
    ctl_next.dz    = d_raw == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_ctl.valid <= 1'b0;
    end else if (en) begin
      pre_ctl.valid <= ctl_next.valid;
    end
    if (en) begin
      pre_ctl.neg_q <= ctl_next.neg_q;
      pre_ctl.neg_r <= ctl_next.neg_r;
      pre_ctl.dz    <= ctl_next.dz;
      pre_nq        <= n_mag;
      pre_d         <= d_mag;
    end
  end

  assign st_ctl[0] = pre_ctl;
  assign st_nq[0]  = pre_nq;
  assign st_r[0]   = '0;
  assign st_d[0]   = pre_d;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    div256_stage #(
      .DW (DIVISOR_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (st_ctl[i]),
      .nq_in   (st_nq[i]),
      .r_in    (st_r[i]),
      .d_in    (st_d[i]),
      .ctl_out (st_ctl[i+1]),
      .nq_out  (st_nq[i+1]),
      .r_out   (st_r[i+1]),
      .d_out   (st_d[i+1])
    );
  end

  always_comb begin
    last_ctl = st_ctl[STEPS];
    last_q   = st_nq[STEPS];
    last_r   = st_r[STEPS];
    r_ext    = RW'(last_r);
    q_next   = last_ctl.neg_q ? (~last_q + NW'(1)) : last_q;
    r_next   = last_ctl.neg_r ? (~r_ext + RW'(1)) : r_ext;
    if (last_ctl.dz) begin
      q_next = '0;
      r_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= last_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.quotient_w0  <= q_next[WW-1:0];
      rsp.quotient_w1  <= q_next[2*WW-1:WW];
      rsp.quotient_w2  <= q_next[3*WW-1:2*WW];
      rsp.quotient_w3  <= q_next[4*WW-1:3*WW];
      rsp.remainder_lo <= r_next[WW-1:0];
      rsp.remainder_hi <= r_next[2*WW-1:WW];
      rsp.div_by_zero  <= last_ctl.dz;
    end
  end

`ifndef ASSERT_OFF
  // a held result must freeze the input side
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("input accepted while result stalled");

  // zero divisor results are cleared
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.div_by_zero) |->
      (rsp.quotient_w0 == '0 && rsp.quotient_w1 == '0 && rsp.quotient_w2 == '0 &&
       rsp.quotient_w3 == '0 && rsp.remainder_lo == '0 && rsp.remainder_hi == '0))
    else $error("nonzero result on zero divisor");

  // partial remainder stays below the divisor magnitude
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    last_ctl.valid |-> (last_ctl.dz || last_r < st_d[STEPS]))
    else $error("remainder not below divisor");

  // a result appears only when an item reached the last step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(last_ctl.valid))
    else $error("result without item");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("valid after reset");
`endif

endmodule

// ----- rtl/div256_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// div256_stage
// One restoring division step: shift in a dividend bit, trial subtract,
// shift the quotient bit into the freed low end of the dividend word.
// ----------------------------------------------------------------------------
module div256_stage #(
  parameter int DW = div256_pkg::DIVISOR_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  div256_pkg::div256_ctl_t               ctl_in,
  input  logic [div256_pkg::DIVIDEND_WIDTH-1:0] nq_in,
  input  logic [DW-1:0]                         r_in,
  input  logic [DW-1:0]                         d_in,
  output div256_pkg::div256_ctl_t               ctl_out,
  output logic [div256_pkg::DIVIDEND_WIDTH-1:0] nq_out,
  output logic [DW-1:0]                         r_out,
  output logic [DW-1:0]                         d_out
);

  localparam int NW = div256_pkg::DIVIDEND_WIDTH;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] r_next;

  always_comb begin
    trial  = {r_in, nq_in[NW-1]};
    diff   = trial - {1'b0, d_in};
    ge     = trial >= {1'b0, d_in};
    r_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.neg_q <= ctl_in.neg_q;
      ctl_out.neg_r <= ctl_in.neg_r;
      ctl_out.dz    <= ctl_in.dz;
      nq_out        <= {nq_in[NW-2:0], ge};
      r_out         <= r_next;
      d_out         <= d_in;
    end
  end

endmodule
